// ===== rtl/ppsch_pkg.sv =====
// shared types, constants and microcode table of the priority scheduler
package ppsch_pkg;

    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int TIME_W   = 16;
    localparam int PRI_W    = 8;
    localparam int JOB_W    = 5;
    localparam int ACT_W    = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_FETCH,
        ST_CHECK,
        ST_SCAN,
        ST_PICK,
        ST_UPDATE,
        ST_WCALC,
        ST_EMIT
    } t_step;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NOT_TICK,
        C_ALL_DONE,
        C_SCAN_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  scan_init;
        logic  scan;
        logic  pick_rd;
        logic  update;
        logic  wcalc;
        logic  emit;
        t_cond cond;
        t_step target;
        t_step next;
    } t_uword;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRI_W-1:0]  pri;
        logic [TIME_W-1:0] remain;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // control store: one word per step
    function automatic t_uword ucode(t_step s);
        t_uword w;
        w = '{accept: 1'b0, scan_init: 1'b0, scan: 1'b0, pick_rd: 1'b0, update: 1'b0,
              wcalc: 1'b0, emit: 1'b0, cond: C_NEVER, target: ST_FETCH, next: ST_FETCH};
        unique case (s)
            ST_FETCH: begin
                w.accept = 1'b1;
                w.cond   = C_NOT_TICK;
                w.target = ST_FETCH;
                w.next   = ST_CHECK;
            end
            ST_CHECK: begin
                w.scan_init = 1'b1;
                w.cond      = C_ALL_DONE;
                w.target    = ST_EMIT;
                w.next      = ST_SCAN;
            end
            ST_SCAN: begin
                w.scan   = 1'b1;
                w.cond   = C_SCAN_MORE;
                w.target = ST_SCAN;
                w.next   = ST_PICK;
            end
            ST_PICK: begin
                w.pick_rd = 1'b1;
                w.next    = ST_UPDATE;
            end
            ST_UPDATE: begin
                w.update = 1'b1;
                w.next   = ST_WCALC;
            end
            ST_WCALC: begin
                w.wcalc = 1'b1;
                w.next  = ST_EMIT;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_BUSY;
                w.target = ST_EMIT;
                w.next   = ST_FETCH;
            end
            default: begin
                w.next = ST_FETCH;
            end
        endcase
        return w;
    endfunction

    function automatic logic [TIME_W-1:0] time_after(logic [TIME_W-1:0] t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

endpackage

// ===== rtl/preemptive_priority_scheduler.sv =====
// top level of the tick driven preemptive priority scheduler
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------------
//  in      | i_valid | o_ready | i_action i_arrival_time i_burst_length
//          |         |         | i_priority_level
//  out     | o_valid | i_ready | o_tick_time o_running_job o_job_finished
//          |         |         | o_turnaround o_waiting o_all_done
//
//  clear, load and unknown actions give no result
//  a tick steps through check, then one table read per loaded slot through the
//  single read port of the job table, then pick read, update, waiting calc, emit
//  a tick with nothing left to run goes from check straight to emit
//  reset clears counts, time and finished flags; table contents stay undefined
//  a tick holds in its emit step while the output register is still full
module preemptive_priority_scheduler (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ppsch_pkg::ACT_W-1:0]  i_action,
    input  logic [ppsch_pkg::TIME_W-1:0] i_arrival_time,
    input  logic [ppsch_pkg::TIME_W-1:0] i_burst_length,
    input  logic [ppsch_pkg::PRI_W-1:0]  i_priority_level,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [ppsch_pkg::TIME_W-1:0] o_tick_time,
    output logic [ppsch_pkg::JOB_W-1:0]  o_running_job,
    output logic                      o_job_finished,
    output logic [ppsch_pkg::TIME_W-1:0] o_turnaround,
    output logic [ppsch_pkg::TIME_W-1:0] o_waiting,
    output logic                      o_all_done
);

    import ppsch_pkg::*;

    t_step r_step, n_step;
    t_uword uw;

    logic [CNT_W-1:0]    r_job_cnt, n_job_cnt;
    logic [CNT_W-1:0]    r_fin_cnt, n_fin_cnt;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [MAX_JOBS-1:0] r_flags, n_flags;
    logic                r_found, n_found;
    logic                r_fin, n_fin;
    logic                r_out_valid, n_out_valid;

    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_pick;
    logic [PRI_W-1:0]    r_best_pri;
    logic [TIME_W-1:0]   r_start;
    logic [TIME_W-1:0]   r_tat;
    logic [TIME_W-1:0]   r_burst;
    logic [TIME_W-1:0]   r_wait;

    logic [TIME_W-1:0]   r_o_tick_time;
    logic [JOB_W-1:0]    r_o_running_job;
    logic                r_o_job_finished;
    logic [TIME_W-1:0]   r_o_turnaround;
    logic [TIME_W-1:0]   r_o_waiting;
    logic                r_o_all_done;

    logic                in_xfer;
    logic                out_busy;
    logic                emit_fire;
    logic                cond_hit;
    logic                do_load;
    logic [CNT_W-1:0]    idx_nxt;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    t_entry              ram_rdata;

    logic                elig;
    logic [TIME_W-1:0]   rem_dec;
    logic [TIME_W-1:0]   load_burst;
    logic [TIME_W-1:0]   time_nxt;
    logic [IDX_W:0]      job_id;

    assign uw        = ucode(r_step);
    assign o_ready   = uw.accept;
    assign in_xfer   = i_valid && uw.accept;
    assign out_busy  = r_out_valid && !i_ready;
    assign emit_fire = uw.emit && !out_busy;
    assign do_load   = in_xfer && (i_action == ACT_LOAD) && (r_job_cnt < CNT_W'(MAX_JOBS));
    assign idx_nxt   = CNT_W'({1'b0, r_idx} + 1'b1);
    assign load_burst = (i_burst_length == '0) ? TIME_W'(1) : i_burst_length;
    assign time_nxt  = time_after(r_start);
    assign rem_dec   = (ram_rdata.remain != '0) ? ram_rdata.remain - 1'b1 : ram_rdata.remain;
    assign elig      = (ram_rdata.arrival <= r_start) && !r_flags[r_idx];
    assign job_id    = {1'b0, r_pick} + 1'b1;

    ppsch_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_JOBS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // table ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pick;
        ram_wdata = ram_rdata;
        ram_raddr = r_pick;
        if (do_load) begin
            ram_we    = 1'b1;
            ram_waddr = r_job_cnt[IDX_W-1:0];
            ram_wdata = '{arrival: i_arrival_time, burst: load_burst,
                          pri: i_priority_level, remain: load_burst};
        end else if (uw.update && r_found) begin
            ram_we           = 1'b1;
            ram_wdata.remain = rem_dec;
        end
        if (uw.scan_init) begin
            ram_raddr = '0;
        end else if (uw.scan) begin
            ram_raddr = idx_nxt[IDX_W-1:0];
        end
    end

    // sequencer branch condition
    always_comb begin
        case (uw.cond)
            C_NOT_TICK:  cond_hit = !(in_xfer && (i_action == ACT_TICK));
            C_ALL_DONE:  cond_hit = (r_fin_cnt >= r_job_cnt);
            C_SCAN_MORE: cond_hit = (idx_nxt != r_job_cnt);
            C_OUT_BUSY:  cond_hit = out_busy;
            default:     cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_step      = cond_hit ? uw.target : uw.next;
        n_job_cnt   = r_job_cnt;
        n_fin_cnt   = r_fin_cnt;
        n_time      = r_time;
        n_flags     = r_flags;
        n_found     = r_found;
        n_fin       = r_fin;
        n_out_valid = r_out_valid;

        if (in_xfer && (i_action == ACT_CLEAR)) begin
            n_job_cnt = '0;
            n_fin_cnt = '0;
            n_time    = '0;
            n_flags   = '0;
        end
        if (do_load) begin
            n_flags[r_job_cnt[IDX_W-1:0]] = 1'b0;
            n_job_cnt = r_job_cnt + 1'b1;
        end
        if (uw.scan_init) begin
            n_found = 1'b0;
            n_fin   = 1'b0;
        end
        if (uw.scan && elig) begin
            n_found = 1'b1;
        end
        if (uw.update) begin
            n_time = time_nxt;
            if (r_found && (rem_dec == '0)) begin
                n_flags[r_pick] = 1'b1;
                n_fin_cnt       = r_fin_cnt + 1'b1;
                n_fin           = 1'b1;
            end
        end
        if (emit_fire) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_FETCH;
            r_job_cnt   <= '0;
            r_fin_cnt   <= '0;
            r_time      <= '0;
            r_flags     <= '0;
            r_found     <= 1'b0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_job_cnt   <= n_job_cnt;
            r_fin_cnt   <= n_fin_cnt;
            r_time      <= n_time;
            r_flags     <= n_flags;
            r_found     <= n_found;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (uw.scan_init) begin
            r_idx   <= '0;
            r_start <= r_time;
        end
        if (uw.scan) begin
            r_idx <= idx_nxt[IDX_W-1:0];
            if (elig && (!r_found || (ram_rdata.pri < r_best_pri))) begin
                r_pick     <= r_idx;
                r_best_pri <= ram_rdata.pri;
            end
        end
        if (uw.update) begin
            r_tat   <= time_nxt - ram_rdata.arrival;
            r_burst <= ram_rdata.burst;
        end
        if (uw.wcalc) begin
            r_wait <= (r_tat >= r_burst) ? r_tat - r_burst : '0;
        end
        if (emit_fire) begin
            r_o_tick_time    <= r_start;
            r_o_running_job  <= r_found ? JOB_W'(job_id) : '0;
            r_o_job_finished <= r_fin;
            r_o_turnaround   <= r_fin ? r_tat : '0;
            r_o_waiting      <= r_fin ? r_wait : '0;
            r_o_all_done     <= (r_fin_cnt >= r_job_cnt);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_tick_time    = r_o_tick_time;
    assign o_running_job  = r_o_running_job;
    assign o_job_finished = r_o_job_finished;
    assign o_turnaround   = r_o_turnaround;
    assign o_waiting      = r_o_waiting;
    assign o_all_done     = r_o_all_done;

endmodule

// ===== rtl/ppsch_ram.sv =====
// generic single write port ram with registered read
module ppsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
